[design/ogws_pkg.sv]
// ogws_pkg: shared constants and codes for the occupancy grid window search unit
// no dependencies; used by the top level and the testbench
`timescale 1ns / 1ps

package ogws_pkg;

   // default grid geometry and id size
   localparam int GRID_W_DEF     = 256;
   localparam int GRID_H_DEF     = 256;
   localparam int ID_BITS_DEF    = 8;
   localparam int MAX_RADIUS_DEF = 8;

   // fixed field widths of the command and register interfaces
   localparam int POS_W    = 12;
   localparam int SIZE_W   = 9;
   localparam int RADIUS_W = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 12;

   // signed width of relative coordinates and window bounds
   localparam int COORD_W = 14;

   // register reset values
   localparam logic [SIZE_W-1:0] AREA_SIZE_RST = 9'd256;

   // command codes
   typedef enum logic [1:0] {
      CMD_ADD  = 2'd0,
      CMD_MOVE = 2'd1,
      CMD_FIND = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X    = 2'd0,
      CSR_ORIGIN_Y    = 2'd1,
      CSR_AREA_WIDTH  = 2'd2,
      CSR_AREA_HEIGHT = 2'd3
   } csr_index_type;

endpackage

[design/ogws_ram.sv]
// ogws_ram: generic single-clock ram, one write and one read port, registered read
// no dependencies
`timescale 1ns / 1ps

module ogws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/occupancy_grid_window_search_unit.sv]
// occupancy_grid_window_search_unit: grid of object ids with add, move and windowed find
// depends on ogws_pkg and ogws_ram
// add and unused commands are answered from dispatch; move runs dispatch, S_MOVE_WR, S_MOVE_CLR
// find: scans the cells of the clipped window up to the first hit or over the whole window
//   (at most 30 x 30 at radius 8), one cell read a cycle through the single ram port and
//   shared address unit; an empty clipped window is answered from the dispatch state
// one transaction at a time: busy is high from accept until the result strobe, the next
//   transaction can be accepted at the edge that takes the result
// reset: registers to origin 0,0 and size 256 x 256, then a clearing pass over all
//   GRID_W*GRID_H cells (65536 by default) with busy high; csr writes are taken throughout
// the result strobe lasts one cycle and cannot be held off
`timescale 1ns / 1ps

module occupancy_grid_window_search_unit #(
   parameter int GRID_W     = ogws_pkg::GRID_W_DEF,
   parameter int GRID_H     = ogws_pkg::GRID_H_DEF,
   parameter int ID_BITS    = ogws_pkg::ID_BITS_DEF,
   parameter int MAX_RADIUS = ogws_pkg::MAX_RADIUS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // command channel
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_cmd,
   input  logic [ogws_pkg::POS_W-1:0]      req_pos_x,
   input  logic [ogws_pkg::POS_W-1:0]      req_pos_y,
   input  logic [ogws_pkg::POS_W-1:0]      req_new_x,
   input  logic [ogws_pkg::POS_W-1:0]      req_new_y,
   input  logic [ID_BITS-1:0]              req_object_id,
   input  logic [ogws_pkg::RADIUS_W-1:0]   req_radius,
   // result channel
   output logic                            rsp_valid,
   output logic                            rsp_hit,
   output logic [ID_BITS-1:0]              rsp_found_id,
   output logic                            rsp_error,
   // register write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ogws_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ogws_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int DEPTH = GRID_W * GRID_H;
   localparam int AW    = $clog2(DEPTH);
   localparam int XB    = $clog2(GRID_W);
   localparam int YB    = $clog2(GRID_H);
   localparam int RW    = $clog2(MAX_RADIUS + 1);
   localparam int CW    = ogws_pkg::COORD_W;

   typedef enum logic [6:0] {
      S_CLEAR    = 7'b0000001,
      S_IDLE     = 7'b0000010,
      S_DISPATCH = 7'b0000100,
      S_MOVE_WR  = 7'b0001000,
      S_MOVE_CLR = 7'b0010000,
      S_SCAN     = 7'b0100000,
      S_SPARE    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [ogws_pkg::POS_W-1:0]  origin_x_ff, origin_y_ff;
   logic [ogws_pkg::SIZE_W-1:0] area_width_ff, area_height_ff;

   // latched transaction
   ogws_pkg::cmd_type       cmd_ff, cmd_in;
   logic signed [CW-1:0]    px_ff, py_ff, nx_ff, ny_ff;
   logic signed [CW-1:0]    px_in, py_in, nx_in, ny_in;
   logic [ID_BITS-1:0]      id_ff, id_in;
   logic [RW-1:0]           rad_ff, rad_in;

   // scan window and position
   logic signed [CW-1:0] scan_x_ff, scan_x_in, scan_y_ff, scan_y_in;
   logic signed [CW-1:0] win_y0_ff, win_y0_in, win_x1_ff, win_x1_in, win_y1_ff, win_y1_in;
   logic                 issuing_ff, issuing_in, chk_ff, chk_in, last_ff, last_in;

   // clearing pass
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;

   // result registers
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [ID_BITS-1:0] rsp_found_ff, rsp_found_in;
   logic               rsp_error_ff, rsp_error_in;

   // ram and shared address unit
   logic                 ram_we;
   logic [ID_BITS-1:0]   ram_wdata, ram_rdata;
   logic [AW-1:0]        ram_addr, grid_addr;
   logic signed [CW-1:0] sel_x, sel_y;

   // window arithmetic
   logic signed [CW-1:0] eff_w, eff_h, half, aw_ext, ah_ext;
   logic signed [CW-1:0] wx0, wx1, wy0, wy1;
   logic                 p_in_area, n_in_area, is_last, rad_over;
   logic signed [CW-1:0] x_next, y_next;

   function automatic logic in_area(input logic signed [CW-1:0] x,
                                    input logic signed [CW-1:0] y,
                                    input logic signed [CW-1:0] w,
                                    input logic signed [CW-1:0] h);
      in_area = (x >= 0) && (y >= 0) && (x < w) && (y < h);
   endfunction

   // size in effect, clipped to the grid
   assign aw_ext = signed'(CW'(area_width_ff));
   assign ah_ext = signed'(CW'(area_height_ff));
   assign eff_w  = (aw_ext < signed'(CW'(GRID_W))) ? aw_ext : signed'(CW'(GRID_W));
   assign eff_h  = (ah_ext < signed'(CW'(GRID_H))) ? ah_ext : signed'(CW'(GRID_H));

   assign p_in_area = in_area(px_ff, py_ff, eff_w, eff_h);
   assign n_in_area = in_area(nx_ff, ny_ff, eff_w, eff_h);

   // clipped find window, upper bounds exclusive
   assign half = signed'(CW'({rad_ff, 1'b0})) - CW'(1);
   always_comb begin
      wx0 = px_ff - half;
      wx1 = px_ff + half;
      wy0 = py_ff - half;
      wy1 = py_ff + half;
      if (wx0 < 0) wx0 = '0;
      if (wx1 > eff_w) wx1 = eff_w;
      if (wy0 < 0) wy0 = '0;
      if (wy1 > eff_h) wy1 = eff_h;
   end

   // scan stepping, y inner
   assign y_next  = scan_y_ff + CW'(1);
   assign x_next  = scan_x_ff + CW'(1);
   assign is_last = (x_next >= win_x1_ff) && (y_next >= win_y1_ff);

   // radius saturation at accept
   assign rad_over = ({4'b0, req_radius} > 8'(MAX_RADIUS));

   // shared address unit: column times height plus row
   always_comb begin
      sel_x = px_ff;
      sel_y = py_ff;
      if (state_ff == S_MOVE_WR) begin
         sel_x = nx_ff;
         sel_y = ny_ff;
      end else if (state_ff == S_SCAN) begin
         sel_x = scan_x_ff;
         sel_y = scan_y_ff;
      end
   end
   assign grid_addr = AW'(sel_x[XB-1:0]) * AW'(GRID_H) + AW'(sel_y[YB-1:0]);
   assign ram_addr  = (state_ff == S_CLEAR) ? clr_cnt_ff : grid_addr;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      id_in        = id_ff;
      rad_in       = rad_ff;
      scan_x_in    = scan_x_ff;
      scan_y_in    = scan_y_ff;
      win_y0_in    = win_y0_ff;
      win_x1_in    = win_x1_ff;
      win_y1_in    = win_y1_ff;
      issuing_in   = issuing_ff;
      chk_in       = 1'b0;
      last_in      = last_ff;
      clr_cnt_in   = clr_cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_hit_in   = 1'b0;
      rsp_found_in = '0;
      rsp_error_in = 1'b0;
      ram_we       = 1'b0;
      ram_wdata    = '0;

      unique case (state_ff)
         S_CLEAR: begin
            ram_we     = 1'b1;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd_in   = ogws_pkg::cmd_type'(req_cmd);
               px_in    = signed'(CW'(req_pos_x)) - signed'(CW'(origin_x_ff));
               py_in    = signed'(CW'(req_pos_y)) - signed'(CW'(origin_y_ff));
               nx_in    = signed'(CW'(req_new_x)) - signed'(CW'(origin_x_ff));
               ny_in    = signed'(CW'(req_new_y)) - signed'(CW'(origin_y_ff));
               id_in    = req_object_id;
               rad_in   = rad_over ? RW'(MAX_RADIUS) : RW'(req_radius);
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (cmd_ff)
               ogws_pkg::CMD_ADD: begin
                  ram_we       = p_in_area;
                  ram_wdata    = id_ff;
                  rsp_valid_in = 1'b1;
                  rsp_error_in = !p_in_area;
                  state_in     = S_IDLE;
               end
               ogws_pkg::CMD_MOVE: begin
                  // source read goes out now, data is back in the next state
                  if (p_in_area && n_in_area) begin
                     state_in = S_MOVE_WR;
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_error_in = 1'b1;
                     state_in     = S_IDLE;
                  end
               end
               ogws_pkg::CMD_FIND: begin
                  if ((wx0 >= wx1) || (wy0 >= wy1)) begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     scan_x_in  = wx0;
                     scan_y_in  = wy0;
                     win_y0_in  = wy0;
                     win_x1_in  = wx1;
                     win_y1_in  = wy1;
                     issuing_in = 1'b1;
                     last_in    = 1'b0;
                     state_in   = S_SCAN;
                  end
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            endcase
         end
         S_MOVE_WR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            state_in  = S_MOVE_CLR;
         end
         S_MOVE_CLR: begin
            // clearing the source last empties a move onto the same cell
            ram_we       = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_SCAN: begin
            priority if (chk_ff && (ram_rdata != '0)) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b1;
               rsp_found_in = ram_rdata;
               state_in     = S_IDLE;
            end else if (chk_ff && last_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (issuing_ff) begin
               chk_in     = 1'b1;
               last_in    = is_last;
               issuing_in = !is_last;
               if (y_next < win_y1_ff) begin
                  scan_y_in = y_next;
               end else begin
                  scan_y_in = win_y0_ff;
                  scan_x_in = x_next;
               end
            end else begin
               chk_in = 1'b0;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         issuing_ff   <= 1'b0;
         chk_ff       <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         issuing_ff   <= issuing_in;
         chk_ff       <= chk_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      nx_ff        <= nx_in;
      ny_ff        <= ny_in;
      id_ff        <= id_in;
      rad_ff       <= rad_in;
      scan_x_ff    <= scan_x_in;
      scan_y_ff    <= scan_y_in;
      win_y0_ff    <= win_y0_in;
      win_x1_ff    <= win_x1_in;
      win_y1_ff    <= win_y1_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_found_ff <= rsp_found_in;
      rsp_error_ff <= rsp_error_in;
   end

   // register writes, always taken
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         area_width_ff  <= ogws_pkg::AREA_SIZE_RST;
         area_height_ff <= ogws_pkg::AREA_SIZE_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (ogws_pkg::csr_index_type'(csr_index))
            ogws_pkg::CSR_ORIGIN_X:    origin_x_ff    <= csr_wdata;
            ogws_pkg::CSR_ORIGIN_Y:    origin_y_ff    <= csr_wdata;
            ogws_pkg::CSR_AREA_WIDTH:  area_width_ff  <= csr_wdata[ogws_pkg::SIZE_W-1:0];
            ogws_pkg::CSR_AREA_HEIGHT: area_height_ff <= csr_wdata[ogws_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // cell store
   ogws_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (DEPTH)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_addr),
      .wr_data (ram_wdata),
      .rd_addr (ram_addr),
      .rd_data (ram_rdata)
   );

   assign busy         = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_found_id = rsp_found_ff;
   assign rsp_error    = rsp_error_ff;

   // a result only follows work in progress
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff != S_IDLE))
      else $error("result strobe without a transaction in progress");

   // a hit always carries a non-empty id
   a_hit_has_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> (rsp_found_id != '0))
      else $error("hit reported with an empty id");

   // error and hit exclude each other
   a_hit_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_error))
      else $error("hit and error in the same result");

   // an accepted transaction goes straight to dispatch
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_DISPATCH))
      else $error("accepted transaction not dispatched");

   // the store is never written while idle
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !ram_we)
      else $error("cell store written while idle");

endmodule

[dv/tb_occupancy_grid_window_search_unit.sv]
// tb_occupancy_grid_window_search_unit: self-checking testbench for the grid window search unit
// depends on ogws_pkg and occupancy_grid_window_search_unit; predicts every result in-bench
`timescale 1ns / 1ps

module tb_occupancy_grid_window_search_unit;

   localparam int CLOCK_HALF     = 6;
   localparam int RESET_CYCLES   = 12;
   localparam int GRID_COLS      = ogws_pkg::GRID_W_DEF;
   localparam int GRID_ROWS      = ogws_pkg::GRID_H_DEF;
   localparam int ID_W           = ogws_pkg::ID_BITS_DEF;
   localparam int RADIUS_CAP     = ogws_pkg::MAX_RADIUS_DEF;
   localparam int POS_W          = ogws_pkg::POS_W;
   localparam int SIZE_W         = ogws_pkg::SIZE_W;
   localparam int RADIUS_W       = ogws_pkg::RADIUS_W;
   localparam int CSR_IDX_W      = ogws_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W     = ogws_pkg::CSR_DATA_W;
   // must outlast the clearing pass after reset and the longest find
   localparam int WATCHDOG_LIMIT = 250000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int END_WAIT_LIMIT = 4000;
   localparam int REPORT_LIMIT   = 40;

   typedef struct packed {
      logic            hit;
      logic [ID_W-1:0] found_id;
      logic            error;
   } grid_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [1:0]            req_cmd;
   logic [POS_W-1:0]      req_pos_x;
   logic [POS_W-1:0]      req_pos_y;
   logic [POS_W-1:0]      req_new_x;
   logic [POS_W-1:0]      req_new_y;
   logic [ID_W-1:0]       req_object_id;
   logic [RADIUS_W-1:0]   req_radius;
   logic                  rsp_valid;
   logic                  rsp_hit;
   logic [ID_W-1:0]       rsp_found_id;
   logic                  rsp_error;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // grid contents and register copies kept by the predictor
   logic [ID_W-1:0]   cell_ids [0:GRID_COLS-1][0:GRID_ROWS-1];
   logic [POS_W-1:0]  origin_x_reg;
   logic [POS_W-1:0]  origin_y_reg;
   logic [SIZE_W-1:0] area_w_reg;
   logic [SIZE_W-1:0] area_h_reg;
   grid_result_type   pending_results [$];

   int mismatches      = 0;
   int commands_sent   = 0;
   int finds_sent      = 0;
   int find_hits       = 0;
   int error_results   = 0;
   int register_writes = 0;
   int area_settings   = 0;
   int idle_pct        = 0;
   int idle_cycles     = 0;

   always #CLOCK_HALF clock = ~clock;

   occupancy_grid_window_search_unit uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_new_x     (req_new_x),
      .req_new_y     (req_new_y),
      .req_object_id (req_object_id),
      .req_radius    (req_radius),
      .rsp_valid     (rsp_valid),
      .rsp_hit       (rsp_hit),
      .rsp_found_id  (rsp_found_id),
      .rsp_error     (rsp_error),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // size in effect, capped at the grid
   function automatic int usable_width();
      return (int'(area_w_reg) < GRID_COLS) ? int'(area_w_reg) : GRID_COLS;
   endfunction

   function automatic int usable_height();
      return (int'(area_h_reg) < GRID_ROWS) ? int'(area_h_reg) : GRID_ROWS;
   endfunction

   function automatic bit in_grid_area(int x, int y);
      return x >= 0 && y >= 0 && x < usable_width() && y < usable_height();
   endfunction

   // applies one command to the grid copy and returns the result it gives
   function automatic grid_result_type predict_grid_command(
      input ogws_pkg::cmd_type   cmd,
      input logic [POS_W-1:0]    pos_x,
      input logic [POS_W-1:0]    pos_y,
      input logic [POS_W-1:0]    new_x,
      input logic [POS_W-1:0]    new_y,
      input logic [ID_W-1:0]     object_id,
      input logic [RADIUS_W-1:0] radius
   );
      int px, py, nx, ny, reach, x0, x1, y0, y1, x, y;
      grid_result_type res;
      res = '0;
      px = int'(pos_x) - int'(origin_x_reg);
      py = int'(pos_y) - int'(origin_y_reg);
      nx = int'(new_x) - int'(origin_x_reg);
      ny = int'(new_y) - int'(origin_y_reg);
      case (cmd)
         ogws_pkg::CMD_ADD: begin
            if (in_grid_area(px, py)) cell_ids[px][py] = object_id;
            else res.error = 1'b1;
         end
         ogws_pkg::CMD_MOVE: begin
            if (in_grid_area(px, py) && in_grid_area(nx, ny)) begin
               cell_ids[nx][ny] = cell_ids[px][py];
               cell_ids[px][py] = '0;
            end else begin
               res.error = 1'b1;
            end
         end
         ogws_pkg::CMD_FIND: begin
            // half-open window of 2r-1 each side, clipped to the area
            reach = 2 * ((int'(radius) > RADIUS_CAP) ? RADIUS_CAP : int'(radius)) - 1;
            x0 = (px - reach < 0) ? 0 : px - reach;
            y0 = (py - reach < 0) ? 0 : py - reach;
            x1 = (px + reach > usable_width()) ? usable_width() : px + reach;
            y1 = (py + reach > usable_height()) ? usable_height() : py + reach;
            for (x = x0; x < x1 && !res.hit; x++) begin
               for (y = y0; y < y1 && !res.hit; y++) begin
                  if (cell_ids[x][y] != '0) begin
                     res.hit      = 1'b1;
                     res.found_id = cell_ids[x][y];
                  end
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int want, input int got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("ERROR at %0t: %s, expected %0d, got %0d", $time, what, want, got);
   endtask

   // one command transaction, with an optional idle gap before it
   task automatic send_command(
      input ogws_pkg::cmd_type   cmd,
      input logic [POS_W-1:0]    pos_x,
      input logic [POS_W-1:0]    pos_y,
      input logic [POS_W-1:0]    new_x,
      input logic [POS_W-1:0]    new_y,
      input logic [ID_W-1:0]     object_id,
      input logic [RADIUS_W-1:0] radius
   );
      grid_result_type want;
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start         <= 1'b1;
      req_cmd       <= cmd;
      req_pos_x     <= pos_x;
      req_pos_y     <= pos_y;
      req_new_x     <= new_x;
      req_new_y     <= new_y;
      req_object_id <= object_id;
      req_radius    <= radius;
      do @(posedge clock); while (busy !== 1'b0);
      want = predict_grid_command(cmd, pos_x, pos_y, new_x, new_y, object_id, radius);
      pending_results.push_back(want);
      commands_sent++;
      if (cmd == ogws_pkg::CMD_FIND) finds_sent++;
      if (want.hit) find_hits++;
      if (want.error) error_results++;
   endtask

   // lets every outstanding transaction complete before registers change
   task automatic settle_block();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input ogws_pkg::csr_index_type reg_index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (reg_index)
         ogws_pkg::CSR_ORIGIN_X:    origin_x_reg = data[POS_W-1:0];
         ogws_pkg::CSR_ORIGIN_Y:    origin_y_reg = data[POS_W-1:0];
         ogws_pkg::CSR_AREA_WIDTH:  area_w_reg   = data[SIZE_W-1:0];
         ogws_pkg::CSR_AREA_HEIGHT: area_h_reg   = data[SIZE_W-1:0];
         default: ;
      endcase
      register_writes++;
   endtask

   // spare upper bits of the size writes carry noise, the block keeps 9 bits
   task automatic set_area(input logic [POS_W-1:0] ox, input logic [POS_W-1:0] oy,
                           input logic [SIZE_W-1:0] width, input logic [SIZE_W-1:0] height);
      settle_block();
      write_register(ogws_pkg::CSR_ORIGIN_X, ox);
      write_register(ogws_pkg::CSR_ORIGIN_Y, oy);
      write_register(ogws_pkg::CSR_AREA_WIDTH, {3'($urandom), width});
      write_register(ogws_pkg::CSR_AREA_HEIGHT, {3'($urandom), height});
      csr_valid <= 1'b0;
      area_settings++;
   endtask

   // mostly inside a cluster of the area, sometimes just outside it or anywhere
   function automatic logic [POS_W-1:0] pick_coord(input logic [POS_W-1:0] origin,
                                                   input int extent, input int base,
                                                   input int span);
      int roll, reach;
      roll  = $urandom_range(0, 99);
      reach = (extent < span) ? extent : span;
      if (extent == 0 || roll < 10) return POS_W'($urandom);
      if (roll < 16) return $urandom_range(0, 1) ? origin - 1'b1 : origin + POS_W'(extent);
      return origin + POS_W'(base + $urandom_range(0, reach - 1));
   endfunction

   task automatic run_traffic(input int count, input int span, input int gap_pct);
      int w, h, roll, base_x, base_y;
      ogws_pkg::cmd_type cmd;
      logic [ID_W-1:0] id;
      logic [RADIUS_W-1:0] rad;
      w = usable_width();
      h = usable_height();
      base_x = (w > span) ? $urandom_range(0, w - span) : 0;
      base_y = (h > span) ? $urandom_range(0, h - span) : 0;
      idle_pct = gap_pct;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < 35) cmd = ogws_pkg::CMD_ADD;
         else if (roll < 55) cmd = ogws_pkg::CMD_MOVE;
         else if (roll < 93) cmd = ogws_pkg::CMD_FIND;
         else cmd = ogws_pkg::CMD_NONE;
         id = ($urandom_range(0, 99) < 8) ? '0 : ID_W'($urandom_range(1, 255));
         // small radii keep scans short, a few saturate
         roll = $urandom_range(0, 99);
         if (roll < 8) rad = '0;
         else if (roll < 70) rad = RADIUS_W'($urandom_range(1, 3));
         else if (roll < 90) rad = RADIUS_W'($urandom_range(4, RADIUS_CAP));
         else rad = RADIUS_W'($urandom_range(RADIUS_CAP + 1, 15));
         send_command(cmd,
                      pick_coord(origin_x_reg, w, base_x, span),
                      pick_coord(origin_y_reg, h, base_y, span),
                      pick_coord(origin_x_reg, w, base_x, span),
                      pick_coord(origin_y_reg, h, base_y, span),
                      id, rad);
      end
      idle_pct = 0;
   endtask

   // every command at the corners of the reset area
   task automatic test_basic_commands();
      send_command(ogws_pkg::CMD_ADD,  12'd0,   12'd0,   12'd0,  12'd0,  8'd255, 4'd0);
      send_command(ogws_pkg::CMD_ADD,  12'd255, 12'd255, 12'd0,  12'd0,  8'd1,   4'd0);
      send_command(ogws_pkg::CMD_ADD,  12'd256, 12'd0,   12'd0,  12'd0,  8'd3,   4'd0);
      send_command(ogws_pkg::CMD_ADD,  12'd0,   12'd256, 12'd0,  12'd0,  8'd3,   4'd0);
      send_command(ogws_pkg::CMD_FIND, 12'd0,   12'd0,   12'd0,  12'd0,  8'd0,   4'd1);
      send_command(ogws_pkg::CMD_FIND, 12'd0,   12'd0,   12'd0,  12'd0,  8'd0,   4'd0);
      send_command(ogws_pkg::CMD_FIND, 12'd255, 12'd255, 12'd0,  12'd0,  8'd0,   4'd15);
      send_command(ogws_pkg::CMD_MOVE, 12'd0,   12'd0,   12'd10, 12'd10, 8'd0,   4'd0);
      send_command(ogws_pkg::CMD_FIND, 12'd10,  12'd10,  12'd0,  12'd0,  8'd0,   4'd1);
      // move onto itself leaves the cell empty
      send_command(ogws_pkg::CMD_MOVE, 12'd10,  12'd10,  12'd10, 12'd10, 8'd0,   4'd0);
      send_command(ogws_pkg::CMD_FIND, 12'd10,  12'd10,  12'd0,  12'd0,  8'd0,   4'd2);
      // id zero clears the cell
      send_command(ogws_pkg::CMD_ADD,  12'd255, 12'd255, 12'd0,  12'd0,  8'd0,   4'd0);
      send_command(ogws_pkg::CMD_NONE, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 8'd255, 4'd15);
      send_command(ogws_pkg::CMD_MOVE, 12'd4095, 12'd0,    12'd0,    12'd0,    8'd0,   4'd0);
      send_command(ogws_pkg::CMD_MOVE, 12'd0,    12'd0,    12'd0,    12'd4095, 8'd0,   4'd0);
      send_command(ogws_pkg::CMD_FIND, 12'd4095, 12'd4095, 12'd0,    12'd0,    8'd0,   4'd8);
   endtask

   // shifted origin, size beyond the grid, and a find centred outside the area
   task automatic test_area_bounds();
      set_area(12'd100, 12'd200, 9'd511, 9'd300);
      send_command(ogws_pkg::CMD_ADD,  12'd100, 12'd200, 12'd0,   12'd0,   8'd7, 4'd0);
      send_command(ogws_pkg::CMD_ADD,  12'd99,  12'd200, 12'd0,   12'd0,   8'd7, 4'd0);
      send_command(ogws_pkg::CMD_ADD,  12'd355, 12'd455, 12'd0,   12'd0,   8'd9, 4'd0);
      send_command(ogws_pkg::CMD_ADD,  12'd356, 12'd200, 12'd0,   12'd0,   8'd9, 4'd0);
      send_command(ogws_pkg::CMD_FIND, 12'd95,  12'd195, 12'd0,   12'd0,   8'd0, 4'd4);
      send_command(ogws_pkg::CMD_MOVE, 12'd355, 12'd455, 12'd100, 12'd201, 8'd0, 4'd0);
   endtask

   // zero-sized area rejects adds and finds nothing, a one-cell area at the top origin
   task automatic test_size_extremes();
      set_area(12'd4095, 12'd4095, 9'd0, 9'd0);
      send_command(ogws_pkg::CMD_ADD,  12'd4095, 12'd4095, 12'd0, 12'd0, 8'd5, 4'd0);
      send_command(ogws_pkg::CMD_FIND, 12'd4095, 12'd4095, 12'd0, 12'd0, 8'd0, 4'd3);
      set_area(12'd4095, 12'd4095, 9'd1, 9'd1);
      send_command(ogws_pkg::CMD_ADD,  12'd4095, 12'd4095, 12'd0, 12'd0, 8'd200, 4'd0);
      send_command(ogws_pkg::CMD_FIND, 12'd4095, 12'd4095, 12'd0, 12'd0, 8'd0,   4'd1);
   endtask

   // random commands over several area settings and idling patterns
   task automatic test_random_traffic();
      set_area(12'd0, 12'd0, 9'd256, 9'd256);
      run_traffic(120, 16, 0);
      set_area(12'd37, 12'd1000, 9'd12, 9'd9);
      run_traffic(110, 16, 58);
      set_area(12'd4095, 12'd4095, 9'd1, 9'd1);
      run_traffic(50, 16, 6);
      set_area(12'd3000, 12'd20, 9'd511, 9'd300);
      run_traffic(100, 24, 58);
      set_area(12'd0, 12'd3800, 9'd2, 9'd256);
      run_traffic(100, 16, 6);
      set_area(12'd500, 12'd600, 9'd40, 9'd33);
      run_traffic(120, 20, 0);
      set_area(12'd1234, 12'd55, 9'd0, 9'd7);
      run_traffic(30, 16, 58);
   endtask

   // result checker: compares each strobe with the oldest prediction
   always @(posedge clock) begin : check_results
      grid_result_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with no command outstanding", 0, 1);
         end else begin
            want = pending_results.pop_front();
            if (rsp_hit !== want.hit) report_mismatch("hit", want.hit, rsp_hit);
            if (rsp_found_id !== want.found_id)
               report_mismatch("found_id", want.found_id, rsp_found_id);
            if (rsp_error !== want.error) report_mismatch("error", want.error, rsp_error);
         end
      end
   end

   // watchdog on cycles with no transaction on any channel
   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1 ||
          (csr_valid === 1'b1 && csr_ready === 1'b1))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("** occupancy_grid_window_search_unit: FAILED **");
         $finish;
      end
   end

   initial begin : run_tests
      int n;
      reset         <= 1'b1;
      start         <= 1'b0;
      req_cmd       <= ogws_pkg::CMD_NONE;
      req_pos_x     <= '0;
      req_pos_y     <= '0;
      req_new_x     <= '0;
      req_new_y     <= '0;
      req_object_id <= '0;
      req_radius    <= '0;
      csr_valid     <= 1'b0;
      csr_index     <= ogws_pkg::CSR_ORIGIN_X;
      csr_wdata     <= '0;
      // predictor starts from the reset state
      origin_x_reg = '0;
      origin_y_reg = '0;
      area_w_reg   = ogws_pkg::AREA_SIZE_RST;
      area_h_reg   = ogws_pkg::AREA_SIZE_RST;
      for (int x = 0; x < GRID_COLS; x++)
         for (int y = 0; y < GRID_ROWS; y++)
            cell_ids[x][y] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_basic_commands();
      test_area_bounds();
      test_size_extremes();
      test_random_traffic();

      // drain, then check nothing is left owing
      start <= 1'b0;
      for (n = 0; n < END_WAIT_LIMIT && pending_results.size() != 0; n++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("results never delivered", pending_results.size(), 0);

      $display("run covered %0d commands over %0d area settings, %0d register writes",
               commands_sent, area_settings, register_writes);
      $display("finds %0d with %0d hits, %0d commands rejected as outside the area, %0d mismatches",
               finds_sent, find_hits, error_results, mismatches);
      if (mismatches == 0)
         $display("** occupancy_grid_window_search_unit: PASSED **");
      else
         $display("** occupancy_grid_window_search_unit: FAILED **");
      $finish;
   end

endmodule
